// File: design/kvlp_pkg.sv
// ----------------------------------------------------------------------------
// kvlp_pkg
// Shared types and constants for the key/value line parser.
// ----------------------------------------------------------------------------
package kvlp_pkg;

    localparam int LINE_BYTES_DEF = 64;
    localparam int LINE_BYTES_MAX = 64;
    localparam int BYTE_W         = 8;
    localparam int LEN_W          = 6;
    localparam int KIND_W         = 2;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;

    typedef enum logic [1:0] {
        OP_STORE = 2'd0,
        OP_OVF   = 2'd1,
        OP_LINE  = 2'd2
    } kvlp_op_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_KEY = 2'd0,
        KIND_VAL = 2'd1,
        KIND_END = 2'd2,
        KIND_OVF = 2'd3
    } kvlp_kind_t;

    function automatic logic is_blank(input logic [BYTE_W-1:0] b);
        return (b == CH_SPACE) || (b == CH_TAB);
    endfunction

endpackage

// File: design/kvlp_ram.sv
// ----------------------------------------------------------------------------
// kvlp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kvlp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/kvlp_fifo.sv
// ----------------------------------------------------------------------------
// kvlp_fifo
// Short command queue between the front classifier and the back engine.
// ----------------------------------------------------------------------------
module kvlp_fifo #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

`ifndef SYNTH
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("queue pushed while full");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("queue popped while empty");
    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("queue count did not advance");
`endif

endmodule

// File: design/kvlp_front.sv
// ----------------------------------------------------------------------------
// kvlp_front
// Accepts received bytes, keeps the fill count and issues store, overflow
// and line-end commands.
// ----------------------------------------------------------------------------
module kvlp_front
    import kvlp_pkg::*;
#(
    parameter int LINE_BYTES = LINE_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rx_valid,
    output logic                          rx_ready,
    input  logic [BYTE_W-1:0]             rx_byte,
    output logic                          cmd_push,
    output kvlp_op_t                      cmd_op,
    output logic [BYTE_W-1:0]             cmd_byte,
    output logic [$clog2(LINE_BYTES)-1:0] cmd_idx,
    input  logic                          cmd_full
);

    localparam int AW = $clog2(LINE_BYTES);
    localparam logic [AW-1:0] LIMIT = AW'(LINE_BYTES - 1);

    logic [AW-1:0] count_reg;
    logic [AW-1:0] count_next;
    logic          take;

    assign rx_ready = !cmd_full;
    assign take     = rx_valid && rx_ready;
    assign cmd_byte = rx_byte;
    assign cmd_idx  = count_reg;

    always_comb
    begin
        count_next = count_reg;
        cmd_push   = 1'b0;
        cmd_op     = OP_STORE;
        if (take && (rx_byte != CH_CR))
        begin
            if (rx_byte == CH_LF)
            begin
                if (count_reg != '0)
                begin
                    cmd_push   = 1'b1;
                    cmd_op     = OP_LINE;
                    count_next = '0;
                end
            end
            else if (count_reg < LIMIT)
            begin
                cmd_push   = 1'b1;
                cmd_op     = OP_STORE;
                count_next = count_reg + AW'(1);
            end
            else
            begin
                cmd_push   = 1'b1;
                cmd_op     = OP_OVF;
                count_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

`ifndef SYNTH
    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= LIMIT)
        else $error("fill count beyond line limit");
    a_line_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_push && cmd_op == OP_LINE) |-> (cmd_idx != '0))
        else $error("line end issued for empty line");
`endif

endmodule

// File: design/kvlp_back.sv
// ----------------------------------------------------------------------------
// kvlp_back
// Executes queued commands: writes the line store, scans an ended line for
// content end, colon and trim bounds; if colon, emits key, value, end marker.
// ----------------------------------------------------------------------------
module kvlp_back
    import kvlp_pkg::*;
#(
    parameter int LINE_BYTES = LINE_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_empty,
    input  kvlp_op_t                      cmd_op,
    input  logic [BYTE_W-1:0]             cmd_byte,
    input  logic [$clog2(LINE_BYTES)-1:0] cmd_idx,
    output logic                          cmd_pop,
    output logic                          res_valid,
    input  logic                          res_ready,
    output logic [KIND_W-1:0]             kind,
    output logic [BYTE_W-1:0]             data_byte,
    output logic [LEN_W-1:0]              key_length,
    output logic [LEN_W-1:0]              value_length,
    output logic                          last
);

    localparam int AW = $clog2(LINE_BYTES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_EMIT_RD,
        S_EMIT_WAIT,
        S_MARK,
        S_OVF
    } state_t;

    state_t            state_reg, state_next;
    logic [AW-1:0]     i_reg, i_next;
    logic [AW-1:0]     n_reg, n_next;
    logic              colon_reg, colon_next;
    logic              kseen_reg, kseen_next;
    logic              vseen_reg, vseen_next;
    logic [AW-1:0]     ks_reg, ks_next;
    logic [AW-1:0]     ke_reg, ke_next;
    logic [AW-1:0]     vs_reg, vs_next;
    logic [AW-1:0]     ve_reg, ve_next;
    logic [AW-1:0]     ptr_reg, ptr_next;
    logic              pval_reg, pval_next;
    logic              valid_reg, valid_next;
    kvlp_kind_t        kind_reg, kind_next;
    logic [BYTE_W-1:0] data_reg, data_next;
    logic [LEN_W-1:0]  klen_reg, klen_next;
    logic [LEN_W-1:0]  vlen_reg, vlen_next;
    logic              last_reg, last_next;

    logic              ram_we;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [BYTE_W-1:0] ram_rdata;
    logic              out_free;

    kvlp_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (LINE_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cmd_idx),
        .wdata (cmd_byte),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free     = !valid_reg || res_ready;
    assign res_valid    = valid_reg;
    assign kind         = kind_reg;
    assign data_byte    = data_reg;
    assign key_length   = klen_reg;
    assign value_length = vlen_reg;
    assign last         = last_reg;

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        n_next     = n_reg;
        colon_next = colon_reg;
        kseen_next = kseen_reg;
        vseen_next = vseen_reg;
        ks_next    = ks_reg;
        ke_next    = ke_reg;
        vs_next    = vs_reg;
        ve_next    = ve_reg;
        ptr_next   = ptr_reg;
        pval_next  = pval_reg;
        valid_next = valid_reg && !res_ready;
        kind_next  = kind_reg;
        data_next  = data_reg;
        klen_next  = klen_reg;
        vlen_next  = vlen_reg;
        last_next  = last_reg;
        cmd_pop    = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_raddr  = ptr_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop = 1'b1;
                    unique case (cmd_op)
                        OP_STORE: ram_we = 1'b1;
                        OP_OVF:   state_next = S_OVF;
                        OP_LINE:
                        begin
                            n_next     = cmd_idx;
                            i_next     = '0;
                            colon_next = 1'b0;
                            kseen_next = 1'b0;
                            vseen_next = 1'b0;
                            ks_next    = '0;
                            ke_next    = '0;
                            state_next = S_SCAN_RD;
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN_RD:
            begin
                if (i_reg == n_reg)
                begin
                    ptr_next   = ks_reg;
                    pval_next  = 1'b0;
                    state_next = colon_reg ? S_EMIT_RD : S_IDLE;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = i_reg;
                    state_next = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK:
            begin
                if (ram_rdata == '0)
                begin
                    ptr_next   = ks_reg;
                    pval_next  = 1'b0;
                    state_next = colon_reg ? S_EMIT_RD : S_IDLE;
                end
                else
                begin
                    if (!colon_reg)
                    begin
                        if (ram_rdata == CH_COLON)
                        begin
                            colon_next = 1'b1;
                            vs_next    = i_reg + AW'(1);
                            ve_next    = i_reg + AW'(1);
                        end
                        else if (!is_blank(ram_rdata))
                        begin
                            if (!kseen_reg)
                            begin
                                ks_next    = i_reg;
                                kseen_next = 1'b1;
                            end
                            ke_next = i_reg + AW'(1);
                        end
                    end
                    else if (!is_blank(ram_rdata))
                    begin
                        if (!vseen_reg)
                        begin
                            vs_next    = i_reg;
                            vseen_next = 1'b1;
                        end
                        ve_next = i_reg + AW'(1);
                    end
                    i_next     = i_reg + AW'(1);
                    state_next = S_SCAN_RD;
                end
            end
            S_EMIT_RD:
            begin
                if (!pval_reg && ptr_reg == ke_reg)
                begin
                    pval_next = 1'b1;
                    ptr_next  = vs_reg;
                end
                else if (pval_reg && ptr_reg == ve_reg)
                begin
                    state_next = S_MARK;
                end
                else
                begin
                    ram_re     = 1'b1;
                    state_next = S_EMIT_WAIT;
                end
            end
            S_EMIT_WAIT:
            begin
                if (out_free)
                begin
                    valid_next = 1'b1;
                    kind_next  = pval_reg ? KIND_VAL : KIND_KEY;
                    data_next  = ram_rdata;
                    klen_next  = '0;
                    vlen_next  = '0;
                    last_next  = 1'b0;
                    ptr_next   = ptr_reg + AW'(1);
                    state_next = S_EMIT_RD;
                end
            end
            S_MARK:
            begin
                if (out_free)
                begin
                    valid_next = 1'b1;
                    kind_next  = KIND_END;
                    data_next  = '0;
                    klen_next  = LEN_W'(ke_reg - ks_reg);
                    vlen_next  = LEN_W'(ve_reg - vs_reg);
                    last_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_OVF:
            begin
                if (out_free)
                begin
                    valid_next = 1'b1;
                    kind_next  = KIND_OVF;
                    data_next  = '0;
                    klen_next  = '0;
                    vlen_next  = '0;
                    last_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg     <= i_next;
        n_reg     <= n_next;
        colon_reg <= colon_next;
        kseen_reg <= kseen_next;
        vseen_reg <= vseen_next;
        ks_reg    <= ks_next;
        ke_reg    <= ke_next;
        vs_reg    <= vs_next;
        ve_reg    <= ve_next;
        ptr_reg   <= ptr_next;
        pval_reg  <= pval_next;
        kind_reg  <= kind_next;
        data_reg  <= data_next;
        klen_reg  <= klen_next;
        vlen_reg  <= vlen_next;
        last_reg  <= last_next;
    end

`ifndef SYNTH
    a_byte_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && (kind_reg == KIND_KEY || kind_reg == KIND_VAL)) |-> !last_reg)
        else $error("key or value byte flagged last");
    a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && (kind_reg == KIND_END || kind_reg == KIND_OVF))
            |-> (last_reg && data_reg == '0))
        else $error("marker without last or with data");
    a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT_RD || state_reg == S_EMIT_WAIT || state_reg == S_MARK)
            |-> (ke_reg >= ks_reg && ve_reg >= vs_reg))
        else $error("trim bounds inverted");
`endif

endmodule

// File: design/key_value_line_parser_top.sv
// ----------------------------------------------------------------------------
// key_value_line_parser_top
// Line-buffered key/value command parser: queue-decoupled front and back.
// Flow: a stored byte is queued, then written when the back engine is idle; a
// line end scans each stored byte (read, check) and, if it held a colon, emits
// key and value bytes (read, wait) and an end marker; overflow emits a marker.
// Throughput: one input item per cycle while the 4-entry command queue has
// room; the back engine's single RAM read port sets the line-end cost.
// Reset: rst_n async, clears fill count, queue and state; line store is not.
// ----------------------------------------------------------------------------
module key_value_line_parser_top
    import kvlp_pkg::*;
#(
    parameter int LINE_BYTES = LINE_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rx_valid,
    output logic              rx_ready,
    input  logic [BYTE_W-1:0] rx_byte,
    output logic              res_valid,
    input  logic              res_ready,
    output logic [KIND_W-1:0] kind,
    output logic [BYTE_W-1:0] data_byte,
    output logic [LEN_W-1:0]  key_length,
    output logic [LEN_W-1:0]  value_length,
    output logic              last
);

    localparam int AW = $clog2(LINE_BYTES);
    localparam int QW = 2 + BYTE_W + AW;

    logic              push;
    kvlp_op_t          f_op;
    logic [BYTE_W-1:0] f_byte;
    logic [AW-1:0]     f_idx;
    logic              q_full;
    logic              q_empty;
    logic              q_pop;
    logic [QW-1:0]     q_din;
    logic [QW-1:0]     q_dout;
    kvlp_op_t          b_op;

    kvlp_front #(
        .LINE_BYTES (LINE_BYTES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx_valid),
        .rx_ready (rx_ready),
        .rx_byte  (rx_byte),
        .cmd_push (push),
        .cmd_op   (f_op),
        .cmd_byte (f_byte),
        .cmd_idx  (f_idx),
        .cmd_full (q_full)
    );

    assign q_din = {f_op, f_byte, f_idx};

    kvlp_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (q_din),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_dout),
        .empty (q_empty)
    );

    assign b_op = kvlp_op_t'(q_dout[QW-1 -: 2]);

    kvlp_back #(
        .LINE_BYTES (LINE_BYTES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_empty    (q_empty),
        .cmd_op       (b_op),
        .cmd_byte     (q_dout[AW +: BYTE_W]),
        .cmd_idx      (q_dout[AW-1:0]),
        .cmd_pop      (q_pop),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .kind         (kind),
        .data_byte    (data_byte),
        .key_length   (key_length),
        .value_length (value_length),
        .last         (last)
    );

endmodule
